>>> rtl/bedc_pkg.sv
`timescale 1ns / 1ps
package bedc_pkg;

    // cursor coordinate width and derived delta width
    localparam int COORD_BITS = 16;
    localparam int DELTA_BITS = COORD_BITS + 1;

    localparam int NUM_BTN  = 3;
    localparam int BTN_LEFT   = 0;
    localparam int BTN_RIGHT  = 1;
    localparam int BTN_MIDDLE = 2;

    localparam int TIME_BITS = 32;
    localparam int DCM_BITS  = 16;
    localparam logic [DCM_BITS-1:0] DCM_RESET = 16'd500;

    // per-button classification code
    typedef enum logic [2:0] {
        ST_NONE = 3'd0,
        ST_DOWN = 3'd1,
        ST_UP   = 3'd2,
        ST_HELD = 3'd3,
        ST_DBL  = 3'd4
    } t_btn_st;

    // click counter values
    localparam logic [1:0] CNT_ZERO = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef t_btn_st t_lane_vec [NUM_BTN];

endpackage

>>> rtl/button_edge_and_double_click_core.sv
`timescale 1ns / 1ps
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------------
// input    | i_in_valid / o_in_ready    | i_button_*, i_now_ms, i_cursor_x/y
// output   | o_out_valid / i_out_ready  | o_state_*, o_delta_x/y
// config   | i_cfg_valid / o_cfg_ready  | i_cfg_data (double-click interval, ms)
//
// one item per cycle while the output is not stalled; the result is in the
// output register in the cycle after acceptance, set by the three button lanes working side by side
// a new item is taken whenever the output register is empty or being read
// reset is synchronous active low; lanes and previous position clear to zero,
// the interval to 500 ms; config is always ready
module button_edge_and_double_click_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_button_left,
    input  logic                                   i_button_right,
    input  logic                                   i_button_middle,
    input  logic [bedc_pkg::TIME_BITS-1:0]         i_now_ms,
    input  logic signed [bedc_pkg::COORD_BITS-1:0] i_cursor_x,
    input  logic signed [bedc_pkg::COORD_BITS-1:0] i_cursor_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [2:0]                             o_state_left,
    output logic [2:0]                             o_state_right,
    output logic [2:0]                             o_state_middle,
    output logic signed [bedc_pkg::DELTA_BITS-1:0] o_delta_x,
    output logic signed [bedc_pkg::DELTA_BITS-1:0] o_delta_y,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [bedc_pkg::DCM_BITS-1:0]          i_cfg_data
);

    logic [bedc_pkg::DCM_BITS-1:0] r_dcm;
    logic                          take;
    logic                          levels [bedc_pkg::NUM_BTN];
    bedc_pkg::t_lane_vec           lane_st;

    assign o_in_ready  = !o_out_valid || i_out_ready;
    assign take        = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // interval register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcm <= bedc_pkg::DCM_RESET;
        end else if (i_cfg_valid) begin
            r_dcm <= i_cfg_data;
        end
    end

    assign levels[bedc_pkg::BTN_LEFT]   = i_button_left;
    assign levels[bedc_pkg::BTN_RIGHT]  = i_button_right;
    assign levels[bedc_pkg::BTN_MIDDLE] = i_button_middle;

    // one lane per button
    for (genvar g = 0; g < bedc_pkg::NUM_BTN; g++) begin : g_lane
        bedc_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_take   (take),
            .i_level  (levels[g]),
            .i_now_ms (i_now_ms),
            .i_dcm    (r_dcm),
            .o_state  (lane_st[g])
        );
    end

    // merge lanes and cursor delta into the result item
    bedc_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_lane_st      (lane_st),
        .i_cursor_x     (i_cursor_x),
        .i_cursor_y     (i_cursor_y),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_state_left   (o_state_left),
        .o_state_right  (o_state_right),
        .o_state_middle (o_state_middle),
        .o_delta_x      (o_delta_x),
        .o_delta_y      (o_delta_y)
    );

endmodule

>>> rtl/bedc_lane.sv
`timescale 1ns / 1ps
module bedc_lane (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_take,
    input  logic                            i_level,
    input  logic [bedc_pkg::TIME_BITS-1:0]  i_now_ms,
    input  logic [bedc_pkg::DCM_BITS-1:0]   i_dcm,
    output bedc_pkg::t_btn_st               o_state
);

    logic                           r_prev;
    logic [1:0]                     r_cnt;
    logic [bedc_pkg::TIME_BITS-1:0] r_start;
    logic [1:0]                     n_cnt;
    logic [bedc_pkg::TIME_BITS-1:0] n_start;
    logic [bedc_pkg::TIME_BITS-1:0] elapsed;
    logic [bedc_pkg::TIME_BITS-1:0] dcm_ext;
    logic                           ge_dcm;
    logic                           le_dcm;
    logic [1:0]                     cnt_cl;
    logic [1:0]                     cnt_inc;
    bedc_pkg::t_btn_st              edge_st;

    // wrapping elapsed time against the interval
    assign elapsed = i_now_ms - r_start;
    assign dcm_ext = {{(bedc_pkg::TIME_BITS-bedc_pkg::DCM_BITS){1'b0}}, i_dcm};
    assign ge_dcm  = (elapsed >= dcm_ext);
    assign le_dcm  = (elapsed <= dcm_ext);

    // edge classification and click counting
    always_comb begin
        unique case ({r_prev, i_level})
            2'b01:   edge_st = bedc_pkg::ST_DOWN;
            2'b10:   edge_st = bedc_pkg::ST_UP;
            2'b11:   edge_st = bedc_pkg::ST_HELD;
            default: edge_st = bedc_pkg::ST_NONE;
        endcase
        o_state = edge_st;
        n_cnt   = r_cnt;
        n_start = r_start;
        cnt_cl  = (r_cnt == bedc_pkg::CNT_ONE && ge_dcm) ? bedc_pkg::CNT_ZERO : r_cnt;
        cnt_inc = (cnt_cl < bedc_pkg::CNT_TWO) ? cnt_cl + 2'd1 : bedc_pkg::CNT_TWO;
        if (edge_st == bedc_pkg::ST_DOWN) begin
            n_cnt = cnt_inc;
            if (cnt_inc == bedc_pkg::CNT_ONE) begin
                n_start = i_now_ms;
            end
        end else if (edge_st == bedc_pkg::ST_UP) begin
            if (r_cnt == bedc_pkg::CNT_ONE) begin
                n_cnt = cnt_cl;
            end else if (r_cnt >= bedc_pkg::CNT_TWO) begin
                if (le_dcm) begin
                    o_state = bedc_pkg::ST_DBL;
                end
                n_cnt = bedc_pkg::CNT_ZERO;
            end
        end
    end

    // lane state update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b0;
            r_cnt   <= bedc_pkg::CNT_ZERO;
            r_start <= '0;
        end else if (i_take) begin
            r_prev  <= i_level;
            r_cnt   <= n_cnt;
            r_start <= n_start;
        end
    end

endmodule

>>> rtl/bedc_merge.sv
`timescale 1ns / 1ps
module bedc_merge (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_take,
    input  bedc_pkg::t_lane_vec                  i_lane_st,
    input  logic signed [bedc_pkg::COORD_BITS-1:0] i_cursor_x,
    input  logic signed [bedc_pkg::COORD_BITS-1:0] i_cursor_y,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [2:0]                           o_state_left,
    output logic [2:0]                           o_state_right,
    output logic [2:0]                           o_state_middle,
    output logic signed [bedc_pkg::DELTA_BITS-1:0] o_delta_x,
    output logic signed [bedc_pkg::DELTA_BITS-1:0] o_delta_y
);

    logic signed [bedc_pkg::COORD_BITS-1:0] r_prev_x;
    logic signed [bedc_pkg::COORD_BITS-1:0] r_prev_y;
    logic                                   r_valid;
    logic [2:0]                             r_st [bedc_pkg::NUM_BTN];
    logic signed [bedc_pkg::DELTA_BITS-1:0] r_dx;
    logic signed [bedc_pkg::DELTA_BITS-1:0] r_dy;
    logic signed [bedc_pkg::DELTA_BITS-1:0] n_dx;
    logic signed [bedc_pkg::DELTA_BITS-1:0] n_dy;

    // sign-extended cursor deltas
    assign n_dx = {i_cursor_x[bedc_pkg::COORD_BITS-1], i_cursor_x}
                - {r_prev_x[bedc_pkg::COORD_BITS-1], r_prev_x};
    assign n_dy = {i_cursor_y[bedc_pkg::COORD_BITS-1], i_cursor_y}
                - {r_prev_y[bedc_pkg::COORD_BITS-1], r_prev_y};

    // output valid and previous position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else begin
            if (i_take) begin
                r_valid  <= 1'b1;
                r_prev_x <= i_cursor_x;
                r_prev_y <= i_cursor_y;
            end else if (i_out_ready) begin
                r_valid  <= 1'b0;
            end
        end
    end

    // result item register
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            for (int i = 0; i < bedc_pkg::NUM_BTN; i++) begin
                r_st[i] <= i_lane_st[i];
            end
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_state_left   = r_st[bedc_pkg::BTN_LEFT];
    assign o_state_right  = r_st[bedc_pkg::BTN_RIGHT];
    assign o_state_middle = r_st[bedc_pkg::BTN_MIDDLE];
    assign o_delta_x      = r_dx;
    assign o_delta_y      = r_dy;

endmodule
